[rtl/vpnt_pkg.sv]
package vpnt_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Field widths.
  localparam int POS_W  = 32;
  localparam int NRM_W  = 16;
  localparam int COEF_W = 16;

  // Position datapath widths.
  localparam int PPROD_W = COEF_W + POS_W;   // coefficient times position
  localparam int PACC_W  = PPROD_W + 3;      // three products, offset and rounding
  localparam int FRAC_SHIFT = 12;            // Q4.12 coefficient fraction

  // Normal datapath widths.
  localparam int COF_W   = 2 * COEF_W + 1;   // cofactor
  localparam int DPROD_W = COEF_W + COF_W;   // determinant term
  localparam int DET_W   = DPROD_W + 2;
  localparam int TPROD_W = COF_W + NRM_W;
  localparam int TSUM_W  = TPROD_W + 2;
  localparam int MAG_W   = 48;               // magnitude of a transformed normal term
  localparam int LEAD_W  = 6;
  localparam int NMAG_W  = 24;               // normalized magnitude, top bit 23
  localparam int NORM_TOP = NMAG_W - 1;
  localparam int SQ_W    = 2 * NMAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = 25;
  localparam int Q_W     = 15;
  localparam int UNIT_SHIFT = 15;            // twice the unit length of Q2.14
  localparam int NUM_W   = NMAG_W + UNIT_SHIFT + 1;
  localparam int DEN_W   = ROOT_W + 1;

  // Determinant threshold in raw units of 2^-36.
  localparam logic signed [DET_W-1:0] DET_EPS = DET_W'(687);

  // Pipeline depths.
  localparam int FRONT_STAGES = 10;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int DIV_STAGES   = Q_W;
  localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
  localparam logic [CFG_DATA_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X = 3'd0,
    REG_ROW_Y = 3'd1,
    REG_ROW_Z = 3'd2,
    REG_OFF_X = 3'd3,
    REG_OFF_Y = 3'd4,
    REG_OFF_Z = 3'd5
  } cfg_reg_e;

  // Payload that rides along with a vertex through the normal pipeline.
  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][NRM_W-1:0] nrm;
    logic [2:0]            neg;
    logic                  zero;
  } side_t;

  typedef struct packed {
    logic [2:0][NMAG_W-1:0] mag;
    side_t                  side;
  } vec_t;

endpackage

[rtl/vpnt_front.sv]
module vpnt_front (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  logic [2:0][vpnt_pkg::POS_W-1:0]          pos_i,
  input  logic [2:0][vpnt_pkg::NRM_W-1:0]          nrm_i,
  input  logic [2:0][vpnt_pkg::CFG_DATA_W-1:0]     rows_i,
  input  logic [2:0][vpnt_pkg::POS_W-1:0]          off_i,
  output logic                                     valid_o,
  output logic [vpnt_pkg::SUM_W-1:0]               sum_o,
  output vpnt_pkg::vec_t                           vec_o
);

  localparam int NS = vpnt_pkg::FRONT_STAGES;

  logic signed [vpnt_pkg::COEF_W-1:0]  m [3][3];
  logic signed [vpnt_pkg::COF_W-1:0]   c_d [3][3];
  logic signed [vpnt_pkg::PPROD_W-1:0] pp_d [3][3];

  logic [NS-1:0] vld_q;

  // Stage registers.
  logic signed [vpnt_pkg::COF_W-1:0]   c1_q [3][3];
  logic signed [vpnt_pkg::COF_W-1:0]   c2_q [3][3];
  logic signed [vpnt_pkg::PPROD_W-1:0] pp1_q [3][3];
  logic signed [vpnt_pkg::NRM_W-1:0]   n_q [3][3];
  logic signed [vpnt_pkg::DPROD_W-1:0] dp2_q [3];
  logic signed [vpnt_pkg::PACC_W-1:0]  pacc2_q [3];
  logic signed [vpnt_pkg::COF_W-1:0]   nm3_q [3][3];
  logic signed [vpnt_pkg::TPROD_W-1:0] tp4_q [3][3];
  logic [vpnt_pkg::MAG_W-1:0]          mag_q [3][3];
  logic [vpnt_pkg::MAG_W-1:0]          mx6_q;
  logic [vpnt_pkg::LEAD_W-1:0]         lead7_q;
  logic [vpnt_pkg::NMAG_W-1:0]         nmag8_q [3];
  logic [vpnt_pkg::SQ_W-1:0]           sq9_q [3];
  logic [vpnt_pkg::SUM_W-1:0]          sum10_q;
  vpnt_pkg::side_t                     side_q [8];
  vpnt_pkg::vec_t                      vec10_q;

  // Combinational stage results.
  logic [vpnt_pkg::POS_W-1:0]          side_q_d_pos [3];
  logic signed [vpnt_pkg::COF_W-1:0]   nm_d [3][3];
  logic [2:0]                          neg_d;
  logic signed [vpnt_pkg::TSUM_W-1:0]  abs_d [3];
  logic [vpnt_pkg::MAG_W-1:0]          mx_d;
  logic [vpnt_pkg::LEAD_W-1:0]         lead_d;
  logic [vpnt_pkg::NMAG_W-1:0]         nmag_d [3];
  logic [vpnt_pkg::NMAG_W-1:0]         mag9_q [3];
  logic [vpnt_pkg::NMAG_W-1:0]         mag10_q [3];

  // Matrix coefficients, unpacked from the rows.
  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int I1 = (gi + 1) % 3;
      localparam int I2 = (gi + 2) % 3;
      localparam int J1 = (gj + 1) % 3;
      localparam int J2 = (gj + 2) % 3;
      assign m[gi][gj] = $signed(rows_i[gi][vpnt_pkg::COEF_W*gj +: vpnt_pkg::COEF_W]);
      assign c_d[gi][gj] = m[I1][J1] * m[I2][J2] - m[I1][J2] * m[I2][J1];
      assign pp_d[gi][gj] = m[gi][gj] * $signed(pos_i[gj]);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  // Stage 1: cofactors and position products.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      n_q[0][i] <= $signed(nrm_i[i]);
      for (int j = 0; j < 3; j++) begin
        c1_q[i][j]  <= c_d[i][j];
        pp1_q[i][j] <= pp_d[i][j];
      end
    end
  end

  // Stage 2: determinant terms and position sums with offset and rounding.
  always_ff @(posedge clk_i) begin
    n_q[1] <= n_q[0];
    c2_q   <= c1_q;
    for (int i = 0; i < 3; i++) begin
      dp2_q[i]   <= m[0][i] * c1_q[0][i];
      pacc2_q[i] <= ($signed(off_i[i]) <<< vpnt_pkg::FRAC_SHIFT) + pp1_q[i][0]
                    + pp1_q[i][1] + pp1_q[i][2]
                    + vpnt_pkg::PACC_W'(1 << (vpnt_pkg::FRAC_SHIFT - 1));
    end
  end

  // Stage 3: choose the normal matrix and saturate the position.
  always_comb begin
    logic signed [vpnt_pkg::DET_W-1:0]  det;
    logic signed [vpnt_pkg::PACC_W-1:0] sh;
    det = dp2_q[0] + dp2_q[1] + dp2_q[2];
    for (int i = 0; i < 3; i++) begin
      sh = pacc2_q[i] >>> vpnt_pkg::FRAC_SHIFT;
      if (sh > vpnt_pkg::PACC_W'(32'sh7fff_ffff)) begin
        side_q_d_pos[i] = 32'h7fff_ffff;
      end else if (sh < -vpnt_pkg::PACC_W'(33'sh0_8000_0000)) begin
        side_q_d_pos[i] = 32'h8000_0000;
      end else begin
        side_q_d_pos[i] = sh[vpnt_pkg::POS_W-1:0];
      end
      for (int j = 0; j < 3; j++) begin
        if (det > vpnt_pkg::DET_EPS) begin
          nm_d[i][j] = c2_q[i][j];
        end else if (det < -vpnt_pkg::DET_EPS) begin
          nm_d[i][j] = -c2_q[i][j];
        end else begin
          nm_d[i][j] = vpnt_pkg::COF_W'(m[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q[2] <= n_q[1];
    nm3_q  <= nm_d;
    for (int i = 0; i < 3; i++) begin
      side_q[0].pos[i] <= side_q_d_pos[i];
      side_q[0].nrm[i] <= n_q[1][i];
    end
    side_q[0].neg  <= '0;
    side_q[0].zero <= 1'b0;
  end

  // Stage 4: normal products.
  always_ff @(posedge clk_i) begin
    side_q[1] <= side_q[0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tp4_q[i][j] <= nm3_q[i][j] * n_q[2][j];
      end
    end
  end

  // Stage 5: transformed normal, split into sign and magnitude.
  always_comb begin
    logic signed [vpnt_pkg::TSUM_W-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t = tp4_q[i][0] + tp4_q[i][1] + tp4_q[i][2];
      neg_d[i] = t[vpnt_pkg::TSUM_W-1];
      abs_d[i] = neg_d[i] ? (-t) : t;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[2].pos  <= side_q[1].pos;
    side_q[2].nrm  <= side_q[1].nrm;
    side_q[2].zero <= side_q[1].zero;
    side_q[2].neg  <= neg_d;
    for (int i = 0; i < 3; i++) begin
      mag_q[0][i] <= abs_d[i][vpnt_pkg::MAG_W-1:0];
    end
  end

  // Stage 6: largest magnitude and the all-zero test.
  always_comb begin
    logic [vpnt_pkg::MAG_W-1:0] a;
    a = (mag_q[0][0] > mag_q[0][1]) ? mag_q[0][0] : mag_q[0][1];
    mx_d = (a > mag_q[0][2]) ? a : mag_q[0][2];
  end

  always_ff @(posedge clk_i) begin
    mag_q[1]       <= mag_q[0];
    mx6_q          <= mx_d;
    side_q[3].pos  <= side_q[2].pos;
    side_q[3].nrm  <= side_q[2].nrm;
    side_q[3].neg  <= side_q[2].neg;
    side_q[3].zero <= (mx_d == '0);
  end

  // Stage 7: position of the leading one of the largest magnitude.
  always_comb begin
    lead_d = '0;
    for (int k = 0; k < vpnt_pkg::MAG_W; k++) begin
      if (mx6_q[k]) begin
        lead_d = vpnt_pkg::LEAD_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q[2]  <= mag_q[1];
    lead7_q   <= lead_d;
    side_q[4] <= side_q[3];
  end

  // Stage 8: shift all magnitudes so the largest has its top bit at bit 23.
  always_comb begin
    logic [vpnt_pkg::MAG_W-1:0] s;
    for (int i = 0; i < 3; i++) begin
      if (lead7_q >= vpnt_pkg::LEAD_W'(vpnt_pkg::NORM_TOP)) begin
        s = mag_q[2][i] >> (lead7_q - vpnt_pkg::LEAD_W'(vpnt_pkg::NORM_TOP));
      end else begin
        s = mag_q[2][i] << (vpnt_pkg::LEAD_W'(vpnt_pkg::NORM_TOP) - lead7_q);
      end
      nmag_d[i] = s[vpnt_pkg::NMAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    nmag8_q   <= nmag_d;
    side_q[5] <= side_q[4];
  end

  // Stage 9: squares.
  always_ff @(posedge clk_i) begin
    side_q[6] <= side_q[5];
    for (int i = 0; i < 3; i++) begin
      sq9_q[i] <= vpnt_pkg::SQ_W'(nmag8_q[i]) * vpnt_pkg::SQ_W'(nmag8_q[i]);
    end
  end

  // Stage 10: sum of squares.
  always_ff @(posedge clk_i) begin
    logic [vpnt_pkg::NMAG_W-1:0] m8 [3];
    m8 = nmag8_q;
    sum10_q <= vpnt_pkg::SUM_W'(sq9_q[0]) + vpnt_pkg::SUM_W'(sq9_q[1])
               + vpnt_pkg::SUM_W'(sq9_q[2]);
    side_q[7] <= side_q[6];
    for (int i = 0; i < 3; i++) begin
      mag9_q[i] <= m8[i];
    end
  end

  always_comb begin
    vec10_q.side = side_q[7];
    for (int i = 0; i < 3; i++) begin
      vec10_q.mag[i] = mag10_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    mag10_q <= mag9_q;
  end

  assign valid_o = vld_q[NS-1];
  assign sum_o   = sum10_q;
  assign vec_o   = vec10_q;

endmodule

[rtl/vpnt_sqrt.sv]
module vpnt_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [vpnt_pkg::SUM_W-1:0]    sum_i,
  input  vpnt_pkg::vec_t                vec_i,
  output logic                          valid_o,
  output logic [vpnt_pkg::ROOT_W-1:0]   root_o,
  output vpnt_pkg::vec_t                vec_o
);

  localparam int NS = vpnt_pkg::SQRT_STAGES;
  localparam int TW = vpnt_pkg::SUM_W + 2;

  logic [NS-1:0]                vld_q;
  logic [vpnt_pkg::SUM_W-1:0]   rem_q  [NS];
  logic [vpnt_pkg::ROOT_W-1:0]  root_q [NS];
  vpnt_pkg::vec_t               vec_q  [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  // One root bit per stage, most significant first.
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic [vpnt_pkg::SUM_W-1:0]  rem_p;
    logic [vpnt_pkg::ROOT_W-1:0] root_p;
    vpnt_pkg::vec_t              vec_p;
    logic [TW-1:0]               trial;
    logic                        take;

    if (s == 0) begin : g_first
      assign rem_p  = sum_i;
      assign root_p = '0;
      assign vec_p  = vec_i;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign vec_p  = vec_q[s-1];
    end

    assign trial = (TW'(root_p) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = (TW'(rem_p) >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= take ? (rem_p - trial[vpnt_pkg::SUM_W-1:0]) : rem_p;
      root_q[s] <= take ? (root_p | (vpnt_pkg::ROOT_W'(1) << B)) : root_p;
      vec_q[s]  <= vec_p;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign vec_o   = vec_q[NS-1];

endmodule

[rtl/vpnt_div.sv]
module vpnt_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [vpnt_pkg::ROOT_W-1:0]          len_i,
  input  vpnt_pkg::vec_t                       vec_i,
  output logic                                 valid_o,
  output logic [2:0][vpnt_pkg::Q_W-1:0]        quo_o,
  output vpnt_pkg::side_t                      side_o
);

  localparam int NS = vpnt_pkg::DIV_STAGES;
  localparam int NW = vpnt_pkg::NUM_W;

  logic [NS-1:0]                    vld_q;
  logic [2:0][NW-1:0]               rem_q [NS];
  logic [2:0][vpnt_pkg::Q_W-1:0]    quo_q [NS];
  logic [vpnt_pkg::DEN_W-1:0]       den_q [NS];
  vpnt_pkg::side_t                  side_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-1-1:0], valid_i};
    end
  end

  // Restoring division, one quotient bit per stage for all three lanes.
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic [2:0][NW-1:0]            rem_p;
    logic [2:0][vpnt_pkg::Q_W-1:0] quo_p;
    logic [vpnt_pkg::DEN_W-1:0]    den_p;
    vpnt_pkg::side_t               side_p;
    logic [NW-1:0]                 trial;

    if (s == 0) begin : g_first
      // Numerator is twice the unit times the magnitude, plus the length.
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_p[l] = (NW'(vec_i.mag[l]) << vpnt_pkg::UNIT_SHIFT) + NW'(len_i);
      end
      assign quo_p  = '0;
      assign den_p  = {len_i, 1'b0};
      assign side_p = vec_i.side;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign quo_p  = quo_q[s-1];
      assign den_p  = den_q[s-1];
      assign side_p = side_q[s-1];
    end

    assign trial = NW'(den_p) << B;

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 3; l++) begin
        if (rem_p[l] >= trial) begin
          rem_q[s][l] <= rem_p[l] - trial;
          quo_q[s][l] <= quo_p[l] | (vpnt_pkg::Q_W'(1) << B);
        end else begin
          rem_q[s][l] <= rem_p[l];
          quo_q[s][l] <= quo_p[l];
        end
      end
      den_q[s]  <= den_p;
      side_q[s] <= side_p;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

[rtl/vertex_position_normal_transform.sv]
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               pos_x_i..pos_z_i, nrm_x_i..nrm_z_i
// result    out        out_valid_o (strobe)      out_pos_*_o, out_nrm_*_o, normal_kept_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One vertex is accepted every cycle; busy is always low.
// A result passes through the front stages (10), the bit-serial square root
// (25 stages) and the restoring divider (15 stages), then the output register.
// Reset clears the valid bits and loads the identity matrix and zero offset.
// The receiver cannot stall, so the pipeline never holds.
module vertex_position_normal_transform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [vpnt_pkg::POS_W-1:0]        pos_x_i,
  input  logic [vpnt_pkg::POS_W-1:0]        pos_y_i,
  input  logic [vpnt_pkg::POS_W-1:0]        pos_z_i,
  input  logic [vpnt_pkg::NRM_W-1:0]        nrm_x_i,
  input  logic [vpnt_pkg::NRM_W-1:0]        nrm_y_i,
  input  logic [vpnt_pkg::NRM_W-1:0]        nrm_z_i,
  input  logic                              cfg_we_i,
  input  logic [vpnt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vpnt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                              out_valid_o,
  output logic [vpnt_pkg::POS_W-1:0]        out_pos_x_o,
  output logic [vpnt_pkg::POS_W-1:0]        out_pos_y_o,
  output logic [vpnt_pkg::POS_W-1:0]        out_pos_z_o,
  output logic [vpnt_pkg::NRM_W-1:0]        out_nrm_x_o,
  output logic [vpnt_pkg::NRM_W-1:0]        out_nrm_y_o,
  output logic [vpnt_pkg::NRM_W-1:0]        out_nrm_z_o,
  output logic                              normal_kept_o
);

  logic [2:0][vpnt_pkg::CFG_DATA_W-1:0] rows_q;
  logic [2:0][vpnt_pkg::POS_W-1:0]      off_q;

  logic                              front_vld;
  logic [vpnt_pkg::SUM_W-1:0]        front_sum;
  vpnt_pkg::vec_t                    front_vec;
  logic                              sqrt_vld;
  logic [vpnt_pkg::ROOT_W-1:0]       sqrt_root;
  vpnt_pkg::vec_t                    sqrt_vec;
  logic                              div_vld;
  logic [2:0][vpnt_pkg::Q_W-1:0]     div_quo;
  vpnt_pkg::side_t                   div_side;

  logic                              out_vld_q;
  logic [2:0][vpnt_pkg::POS_W-1:0]   out_pos_q;
  logic [2:0][vpnt_pkg::NRM_W-1:0]   out_nrm_q;
  logic [2:0][vpnt_pkg::NRM_W-1:0]   nrm_d;
  logic                              kept_q;
  logic                              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= vpnt_pkg::ROW_X_RESET;
      rows_q[1] <= vpnt_pkg::ROW_Y_RESET;
      rows_q[2] <= vpnt_pkg::ROW_Z_RESET;
      off_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (vpnt_pkg::cfg_reg_e'(cfg_idx_i))
        vpnt_pkg::REG_ROW_X: rows_q[0] <= cfg_wdata_i;
        vpnt_pkg::REG_ROW_Y: rows_q[1] <= cfg_wdata_i;
        vpnt_pkg::REG_ROW_Z: rows_q[2] <= cfg_wdata_i;
        vpnt_pkg::REG_OFF_X: off_q[0]  <= cfg_wdata_i[vpnt_pkg::POS_W-1:0];
        vpnt_pkg::REG_OFF_Y: off_q[1]  <= cfg_wdata_i[vpnt_pkg::POS_W-1:0];
        vpnt_pkg::REG_OFF_Z: off_q[2]  <= cfg_wdata_i[vpnt_pkg::POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  vpnt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pos_i   ({pos_z_i, pos_y_i, pos_x_i}),
    .nrm_i   ({nrm_z_i, nrm_y_i, nrm_x_i}),
    .rows_i  (rows_q),
    .off_i   (off_q),
    .valid_o (front_vld),
    .sum_o   (front_sum),
    .vec_o   (front_vec)
  );

  vpnt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_vld),
    .sum_i   (front_sum),
    .vec_i   (front_vec),
    .valid_o (sqrt_vld),
    .root_o  (sqrt_root),
    .vec_o   (sqrt_vec)
  );

  vpnt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sqrt_vld),
    .len_i   (sqrt_root),
    .vec_i   (sqrt_vec),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // Final normal: pass the input through when the transformed normal is zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_side.zero) begin
        nrm_d[i] = div_side.nrm[i];
      end else if (div_side.neg[i]) begin
        nrm_d[i] = -{1'b0, div_quo[i]};
      end else begin
        nrm_d[i] = {1'b0, div_quo[i]};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pos_q <= div_side.pos;
    out_nrm_q <= nrm_d;
    kept_q    <= div_side.zero;
  end

  assign out_valid_o   = out_vld_q;
  assign out_pos_x_o   = out_pos_q[0];
  assign out_pos_y_o   = out_pos_q[1];
  assign out_pos_z_o   = out_pos_q[2];
  assign out_nrm_x_o   = out_nrm_q[0];
  assign out_nrm_y_o   = out_nrm_q[1];
  assign out_nrm_z_o   = out_nrm_q[2];
  assign normal_kept_o = kept_q;

`ifndef SYNTH
  // Every accepted transaction produces its result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(vpnt_pkg::LATENCY) out_valid_o)
    else $error("accepted transaction produced no result");

  // No result appears without a transaction accepted at the right time.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept && rst_ni, vpnt_pkg::LATENCY))
    else $error("result without matching transaction");

  // A renormalized normal always has a nonzero component.
  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !normal_kept_o) |->
      ((out_nrm_x_o != '0) || (out_nrm_y_o != '0) || (out_nrm_z_o != '0)))
    else $error("renormalized normal is zero");
`endif

endmodule
